/* rtl/mep_pkg.sv */
// ----------------------------------------------------------------------------
// mep_pkg
// Widths, register indexes and helpers shared by the escape-time pixel core.
// ----------------------------------------------------------------------------
package mep_pkg;

   localparam int COORD_BITS     = 32;
   localparam int FRAC_BITS      = COORD_BITS - 4;
   localparam int INDEX_BITS     = 12;
   localparam int COUNT_BITS     = 16;
   localparam int PROD_BITS      = 2 * COORD_BITS;
   localparam int COLOR_BITS     = 8;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = COORD_BITS;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic [COORD_BITS-2:0]        step_type;
   typedef logic [COUNT_BITS-1:0]        count_type;
   typedef logic [INDEX_BITS-1:0]        index_type;
   typedef logic [COLOR_BITS-1:0]        color_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ORIGIN_X = 3'd0,
      CSR_ORIGIN_Y = 3'd1,
      CSR_STEP_X   = 3'd2,
      CSR_STEP_Y   = 3'd3,
      CSR_MAX_ITER = 3'd4
   } csr_index_type;

   localparam count_type MAX_ITER_RESET = COUNT_BITS'(1024);

   // |z|^2 >= 4 with 2*FRAC_BITS fraction bits
   localparam logic [PROD_BITS-1:0] ESC_BOUND = PROD_BITS'(1) << (2 * FRAC_BITS + 2);

   // green ramp folds back from the middle of the palette
   localparam logic [COLOR_BITS:0] GREEN_FOLD = (COLOR_BITS + 1)'(382);

   // clamp a wide signed value to the signed coordinate range
   function automatic coord_type saturate(input prod_type v);
      logic [PROD_BITS-COORD_BITS:0] top;
      coord_type                     res;
      top = v[PROD_BITS-1:COORD_BITS-1];
      if ((&top) || !(|top)) begin
         res = v[COORD_BITS-1:0];
      end else if (v[PROD_BITS-1]) begin
         res = {1'b1, {(COORD_BITS-1){1'b0}}};
      end else begin
         res = {1'b0, {(COORD_BITS-1){1'b1}}};
      end
      return res;
   endfunction

endpackage

/* rtl/mandelbrot_escape_pixel_core.sv */
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_core
// Escape-time engine for one pixel: forms c from the pixel position, iterates
// z = z^2 + c in Q4.28 and returns the count with its palette colour.
//
// One item is taken at a time. Setting up c uses the states MCX, MCY and
// CY, and each pass uses MXX, MYY, MXY and STEP, as x*x, y*y and x*y all
// pass through one 32x32 signed multiplier before the escape test and the
// update share the STEP state; the final pass ends in escape or the limit.
// The input stays stalled from acceptance until the result is written,
// for longer the higher the returned count n, which is at most max_iter.
// The result sits in an output register, so the next item may be
// taken while it waits; a finished item is held back only while an earlier
// result is still stalled there. Write the configuration registers only
// while no item is in flight or waiting.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [mep_pkg::INDEX_BITS-1:0]       req_col,
   input  logic [mep_pkg::INDEX_BITS-1:0]       req_row,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mep_pkg::COUNT_BITS-1:0]       rsp_iter_count,
   output logic                                 rsp_inside_res,
   output logic [mep_pkg::COLOR_BITS-1:0]       rsp_red,
   output logic [mep_pkg::COLOR_BITS-1:0]       rsp_green,
   output logic [mep_pkg::COLOR_BITS-1:0]       rsp_blue,
   input  logic                                 csr_wr_en,
   input  logic [mep_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [mep_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_MCX  = 8'b0000_0010,
      ST_MCY  = 8'b0000_0100,
      ST_CY   = 8'b0000_1000,
      ST_MXX  = 8'b0001_0000,
      ST_MYY  = 8'b0010_0000,
      ST_MXY  = 8'b0100_0000,
      ST_STEP = 8'b1000_0000
   } state_type;

   // control
   state_type           state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   mep_pkg::count_type  n_ff, n_in;

   // configuration
   mep_pkg::coord_type  origin_x_ff, origin_x_in;
   mep_pkg::coord_type  origin_y_ff, origin_y_in;
   mep_pkg::step_type   step_x_ff, step_x_in;
   mep_pkg::step_type   step_y_ff, step_y_in;
   mep_pkg::count_type  max_iter_ff, max_iter_in;

   // datapath
   mep_pkg::index_type  col_ff, col_in;
   mep_pkg::index_type  row_ff, row_in;
   mep_pkg::coord_type  cx_ff, cx_in;
   mep_pkg::coord_type  cy_ff, cy_in;
   mep_pkg::coord_type  x_ff, x_in;
   mep_pkg::coord_type  y_ff, y_in;
   mep_pkg::prod_type   sqx_ff, sqx_in;
   mep_pkg::prod_type   sqy_ff, sqy_in;
   mep_pkg::prod_type   xy_ff, xy_in;

   // result register
   mep_pkg::count_type  rsp_count_ff, rsp_count_in;
   logic                rsp_inside_ff, rsp_inside_in;
   mep_pkg::color_type  rsp_red_ff, rsp_red_in;
   mep_pkg::color_type  rsp_green_ff, rsp_green_in;
   mep_pkg::color_type  rsp_blue_ff, rsp_blue_in;

   // shared multiplier
   mep_pkg::coord_type  mul_a, mul_b;
   mep_pkg::prod_type   mul_p;

   // escape test and update
   logic [mep_pkg::PROD_BITS-1:0] sq_sum;
   logic                          escaped;
   logic                          limit_hit;
   logic                          out_free;
   mep_pkg::prod_type             next_x_wide;
   mep_pkg::prod_type             next_y_wide;
   mep_pkg::color_type            k;

   always_comb begin
      unique case (state_ff)
         ST_MCX: begin
            mul_a = mep_pkg::coord_type'(col_ff);
            mul_b = mep_pkg::coord_type'(step_x_ff);
         end
         ST_MCY: begin
            mul_a = mep_pkg::coord_type'(row_ff);
            mul_b = mep_pkg::coord_type'(step_y_ff);
         end
         ST_MXX: begin
            mul_a = x_ff;
            mul_b = x_ff;
         end
         ST_MYY: begin
            mul_a = y_ff;
            mul_b = y_ff;
         end
         ST_MXY: begin
            mul_a = x_ff;
            mul_b = y_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   assign sq_sum    = $unsigned(sqx_ff) + $unsigned(sqy_ff);
   assign escaped   = (sq_sum >= mep_pkg::ESC_BOUND);
   assign limit_hit = (n_ff >= max_iter_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // floor(2xy / 2^F) taken as floor(xy / 2^(F-1)) so 2xy never overflows
   assign next_x_wide = ((sqx_ff - sqy_ff) >>> mep_pkg::FRAC_BITS)
                        + mep_pkg::prod_type'(cx_ff);
   assign next_y_wide = (xy_ff >>> (mep_pkg::FRAC_BITS - 1))
                        + mep_pkg::prod_type'(cy_ff);

   assign k = n_ff[mep_pkg::COLOR_BITS-1:0];

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      n_in          = n_ff;
      origin_x_in   = origin_x_ff;
      origin_y_in   = origin_y_ff;
      step_x_in     = step_x_ff;
      step_y_in     = step_y_ff;
      max_iter_in   = max_iter_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      sqx_in        = sqx_ff;
      sqy_in        = sqy_ff;
      xy_in         = xy_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_inside_in = rsp_inside_ff;
      rsp_red_in    = rsp_red_ff;
      rsp_green_in  = rsp_green_ff;
      rsp_blue_in   = rsp_blue_ff;

      // drop the waiting item once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wr_en) begin
         unique case (csr_index)
            mep_pkg::CSR_ORIGIN_X: origin_x_in = csr_wdata;
            mep_pkg::CSR_ORIGIN_Y: origin_y_in = csr_wdata;
            mep_pkg::CSR_STEP_X:   step_x_in   = csr_wdata[mep_pkg::COORD_BITS-2:0];
            mep_pkg::CSR_STEP_Y:   step_y_in   = csr_wdata[mep_pkg::COORD_BITS-2:0];
            mep_pkg::CSR_MAX_ITER: max_iter_in = csr_wdata[mep_pkg::COUNT_BITS-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               col_in   = req_col;
               row_in   = req_row;
               n_in     = '0;
               state_in = ST_MCX;
            end
         end
         ST_MCX: begin
            xy_in    = mul_p;
            state_in = ST_MCY;
         end
         ST_MCY: begin
            cx_in    = mep_pkg::saturate(mep_pkg::prod_type'(origin_x_ff) + xy_ff);
            xy_in    = mul_p;
            state_in = ST_CY;
         end
         ST_CY: begin
            cy_in    = mep_pkg::saturate(mep_pkg::prod_type'(origin_y_ff) - xy_ff);
            x_in     = cx_ff;
            y_in     = cy_in;
            state_in = ST_MXX;
         end
         ST_MXX: begin
            sqx_in   = mul_p;
            state_in = ST_MYY;
         end
         ST_MYY: begin
            sqy_in   = mul_p;
            state_in = ST_MXY;
         end
         ST_MXY: begin
            xy_in    = mul_p;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (limit_hit || escaped) begin
               // hold here until the result register is free
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_count_in  = n_ff;
                  rsp_inside_in = limit_hit;
                  if (limit_hit) begin
                     rsp_red_in   = '0;
                     rsp_green_in = '0;
                     rsp_blue_in  = '0;
                  end else begin
                     rsp_red_in  = ~k;
                     rsp_blue_in = k;
                     if (k[mep_pkg::COLOR_BITS-1]) begin
                        rsp_green_in = mep_pkg::color_type'(mep_pkg::GREEN_FOLD
                                       - {1'b0, k});
                     end else begin
                        rsp_green_in = {k[mep_pkg::COLOR_BITS-2:0], 1'b0};
                     end
                  end
                  state_in = ST_IDLE;
               end
            end else begin
               x_in     = mep_pkg::saturate(next_x_wide);
               y_in     = mep_pkg::saturate(next_y_wide);
               n_in     = n_ff + 1'b1;
               state_in = ST_MXX;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         n_ff         <= '0;
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         step_x_ff    <= '0;
         step_y_ff    <= '0;
         max_iter_ff  <= mep_pkg::MAX_ITER_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         n_ff         <= n_in;
         origin_x_ff  <= origin_x_in;
         origin_y_ff  <= origin_y_in;
         step_x_ff    <= step_x_in;
         step_y_ff    <= step_y_in;
         max_iter_ff  <= max_iter_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff        <= col_in;
      row_ff        <= row_in;
      cx_ff         <= cx_in;
      cy_ff         <= cy_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      sqx_ff        <= sqx_in;
      sqy_ff        <= sqy_in;
      xy_ff         <= xy_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_inside_ff <= rsp_inside_in;
      rsp_red_ff    <= rsp_red_in;
      rsp_green_ff  <= rsp_green_in;
      rsp_blue_ff   <= rsp_blue_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_iter_count = rsp_count_ff;
   assign rsp_inside_res = rsp_inside_ff;
   assign rsp_red        = rsp_red_ff;
   assign rsp_green      = rsp_green_ff;
   assign rsp_blue       = rsp_blue_ff;

`ifndef SYNTHESIS
   a_accept_starts_setup : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_MCX && n_ff == '0))
      else $error("accepted item did not start the setup sequence");

   a_result_from_step : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_STEP))
      else $error("result raised outside the step cycle");

   a_count_advances : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MXX && $past(state_ff == ST_STEP))
      |-> (n_ff == mep_pkg::count_type'($past(n_ff) + 1'b1)))
      else $error("iteration count did not advance by one");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && state_ff == ST_STEP && (limit_hit || escaped))
      |=> (state_ff == ST_STEP))
      else $error("finished item left the step cycle with the result slot full");
`endif

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the escape-time pixel core. A predictor iterates
// z = z^2 + c in wide signed arithmetic for every item accepted. The monitor
// compares each returned count, black flag and colour against the oldest
// prediction. Stimulus starts with directed corner pixels: the reset setting,
// zero and full iteration limits, saturated corners, unmapped registers and
// slow escapes. Random regions follow under several idle and stall patterns.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CLOCK_PERIOD    = 8;
   localparam int RESET_CYCLES    = 8;
   localparam int ITEMS_PER_PHASE = 135;
   localparam int RANDOM_PHASES   = 8;
   localparam int REPORT_LIMIT    = 10;
   localparam int LONG_HOLD       = 3000;
   localparam int TAIL_CYCLES     = 32;
   // the slowest pixel, at the full 16-bit limit, keeps the input stalled with nothing moving
   localparam int WATCHDOG_LIMIT  = 4 * (4 * 65536 + 64);

   localparam logic [mep_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED_LO  = 3'd5;
   localparam logic [mep_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED_MID = 3'd6;
   localparam logic [mep_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED_HI  = 3'd7;

   typedef logic signed [71:0] wide_type;

   localparam wide_type COORD_HI  = (wide_type'(1) <<< (mep_pkg::COORD_BITS - 1)) - 1;
   localparam wide_type COORD_LO  = -(wide_type'(1) <<< (mep_pkg::COORD_BITS - 1));
   // |z|^2 >= 4 at 2*FRAC_BITS fraction bits
   localparam wide_type ESCAPE_SQ = wide_type'(1) <<< (2 * mep_pkg::FRAC_BITS + 2);

   typedef struct packed {
      mep_pkg::count_type iter;
      logic               black;
      mep_pkg::color_type red;
      mep_pkg::color_type green;
      mep_pkg::color_type blue;
   } pixel_type;

   typedef struct packed {
      mep_pkg::index_type col;
      mep_pkg::index_type row;
   } pixel_job_type;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;
   typedef enum {VIEW_WHOLE, VIEW_FULL_GRID, VIEW_SEAHORSE, VIEW_NOISE, VIEW_LOW_LIMIT}
      view_kind_type;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   mep_pkg::index_type req_col   = '0;
   mep_pkg::index_type req_row   = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   mep_pkg::count_type rsp_iter_count;
   logic               rsp_inside_res;
   mep_pkg::color_type rsp_red;
   mep_pkg::color_type rsp_green;
   mep_pkg::color_type rsp_blue;
   logic                               csr_wr_en = 1'b0;
   logic [mep_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [mep_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // register copies seen by the predictor
   mep_pkg::coord_type cfg_origin_x = '0;
   mep_pkg::coord_type cfg_origin_y = '0;
   mep_pkg::step_type  cfg_step_x   = '0;
   mep_pkg::step_type  cfg_step_y   = '0;
   mep_pkg::count_type cfg_max_iter = mep_pkg::MAX_ITER_RESET;

   pixel_job_type pixel_jobs[$];
   pixel_type     owed_pixels[$];
   pixel_job_type next_job;

   int unsigned send_idle_pct   = 0;
   int unsigned recv_stall_pct  = 0;
   int unsigned col_span        = 0;
   int unsigned row_span        = 0;
   logic        long_hold_armed = 1'b0;
   logic        long_hold_used  = 1'b0;
   int unsigned hold_left       = 0;
   int unsigned fault_count     = 0;
   int unsigned pixels_checked  = 0;
   int unsigned pixels_sent     = 0;
   int unsigned region_count    = 0;
   int unsigned quiet_cycles    = 0;

   view_kind_type phase_views [RANDOM_PHASES] = '{VIEW_WHOLE, VIEW_FULL_GRID, VIEW_NOISE,
      VIEW_SEAHORSE, VIEW_LOW_LIMIT, VIEW_FULL_GRID, VIEW_NOISE, VIEW_WHOLE};

   mandelbrot_escape_pixel_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_col        (req_col),
      .req_row        (req_row),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_iter_count (rsp_iter_count),
      .rsp_inside_res (rsp_inside_res),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic mep_pkg::coord_type clamp_coord(input wide_type v);
      mep_pkg::coord_type r;
      if (v > COORD_HI) begin
         r = mep_pkg::coord_type'(COORD_HI);
      end else if (v < COORD_LO) begin
         r = mep_pkg::coord_type'(COORD_LO);
      end else begin
         r = mep_pkg::coord_type'(v);
      end
      return r;
   endfunction

   function automatic pixel_type trace_orbit(input mep_pkg::index_type col,
                                             input mep_pkg::index_type row);
      mep_pkg::coord_type cx, cy, x, y, x_next;
      wide_type           xx, yy, xy;
      mep_pkg::count_type n;
      logic               gone;
      mep_pkg::color_type k;
      pixel_type          pix;
      cx   = clamp_coord(wide_type'(cfg_origin_x) + wide_type'(col) * wide_type'(cfg_step_x));
      cy   = clamp_coord(wide_type'(cfg_origin_y) - wide_type'(row) * wide_type'(cfg_step_y));
      x    = cx;
      y    = cy;
      n    = '0;
      gone = 1'b0;
      while (n < cfg_max_iter && !gone) begin
         xx = wide_type'(x) * wide_type'(x);
         yy = wide_type'(y) * wide_type'(y);
         xy = wide_type'(x) * wide_type'(y);
         if (xx + yy >= ESCAPE_SQ) begin
            gone = 1'b1;
         end else begin
            x_next = clamp_coord(((xx - yy) >>> mep_pkg::FRAC_BITS) + wide_type'(cx));
            y      = clamp_coord(((xy + xy) >>> mep_pkg::FRAC_BITS) + wide_type'(cy));
            x      = x_next;
            n      = n + 1'b1;
         end
      end
      k         = n[7:0];
      pix.iter  = n;
      pix.black = (n == cfg_max_iter);
      if (pix.black) begin
         pix.red   = '0;
         pix.green = '0;
         pix.blue  = '0;
      end else begin
         pix.red   = mep_pkg::color_type'(255 - k);
         pix.blue  = k;
         // ramp up to the middle of the palette, then fold back
         pix.green = (k < 8'd128) ? mep_pkg::color_type'(2 * k)
                                  : mep_pkg::color_type'(382 - k);
      end
      return pix;
   endfunction

   // sender: offer queued pixels, hold while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            owed_pixels.push_back(trace_orbit(req_col, req_row));
            pixels_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (pixel_jobs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_job = pixel_jobs.pop_front();
               req_valid <= 1'b1;
               req_col   <= next_job.col;
               req_row   <= next_job.row;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: check each pixel against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_pixels.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT) begin
                  $display("unexpected pixel: iter %0d black %0b rgb %0d/%0d/%0d",
                           rsp_iter_count, rsp_inside_res, rsp_red, rsp_green, rsp_blue);
               end
            end else begin
               pixels_checked++;
               if (owed_pixels[0].iter  !== rsp_iter_count ||
                   owed_pixels[0].black !== rsp_inside_res ||
                   owed_pixels[0].red   !== rsp_red ||
                   owed_pixels[0].green !== rsp_green ||
                   owed_pixels[0].blue  !== rsp_blue) begin
                  fault_count++;
                  if (fault_count <= REPORT_LIMIT) begin
                     $display("pixel mismatch: expected iter %0d black %0b rgb %0d/%0d/%0d",
                              owed_pixels[0].iter, owed_pixels[0].black, owed_pixels[0].red,
                              owed_pixels[0].green, owed_pixels[0].blue);
                     $display("                got iter %0d black %0b rgb %0d/%0d/%0d",
                              rsp_iter_count, rsp_inside_res, rsp_red, rsp_green,
                              rsp_blue);
                  end
               end
               void'(owed_pixels.pop_front());
            end
         end
         if (long_hold_armed && !long_hold_used) begin
            hold_left      = LONG_HOLD;
            long_hold_used = 1'b1;
         end
         rsp_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
         if (hold_left != 0) begin
            hold_left--;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: nothing accepted for %0d cycles", quiet_cycles);
            $display("testbench: FAIL");
            $finish;
         end
      end
   end

   task automatic write_reg(input logic [mep_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [mep_pkg::CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      unique case (idx)
         mep_pkg::CSR_ORIGIN_X: cfg_origin_x = data;
         mep_pkg::CSR_ORIGIN_Y: cfg_origin_y = data;
         mep_pkg::CSR_STEP_X:   cfg_step_x   = data[mep_pkg::COORD_BITS-2:0];
         mep_pkg::CSR_STEP_Y:   cfg_step_y   = data[mep_pkg::COORD_BITS-2:0];
         mep_pkg::CSR_MAX_ITER: cfg_max_iter = data[mep_pkg::COUNT_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic queue_pixel(input int unsigned col, input int unsigned row);
      pixel_jobs.push_back('{col: mep_pkg::index_type'(col),
                             row: mep_pkg::index_type'(row)});
   endtask

   // wait until every queued pixel has been sent and returned
   task automatic settle();
      do begin
         @(negedge clock);
      end while (pixel_jobs.size() != 0 || req_valid || owed_pixels.size() != 0);
   endtask

   task automatic apply_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         IDLE_SENDER:   begin send_idle_pct = 74; recv_stall_pct = 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 74; end
         default:       begin send_idle_pct = 8;  recv_stall_pct = 8;  end
      endcase
   endtask

   task automatic pick_region(input view_kind_type view);
      region_count++;
      case (view)
         VIEW_FULL_GRID: begin
            // 4096 x 4096 grid over [-2.5, 1.5] x [-2, 2]
            write_reg(mep_pkg::CSR_ORIGIN_X, 32'hD800_0000);
            write_reg(mep_pkg::CSR_ORIGIN_Y, 32'h2000_0000);
            write_reg(mep_pkg::CSR_STEP_X, 32'h0004_0000);
            write_reg(mep_pkg::CSR_STEP_Y, 32'h0004_0000);
            write_reg(mep_pkg::CSR_MAX_ITER, {16'($urandom), 16'($urandom_range(48, 128))});
            col_span = 4095;
            row_span = 4095;
         end
         VIEW_SEAHORSE: begin
            write_reg(mep_pkg::CSR_ORIGIN_X, 32'hF333_3334);
            write_reg(mep_pkg::CSR_ORIGIN_Y, 32'h0333_3333);
            write_reg(mep_pkg::CSR_STEP_X, 32'h0001_0000);
            write_reg(mep_pkg::CSR_STEP_Y, 32'h0001_0000);
            write_reg(mep_pkg::CSR_MAX_ITER, 32'($urandom_range(100, 400)));
            col_span = 255;
            row_span = 255;
         end
         VIEW_NOISE: begin
            write_reg(mep_pkg::CSR_ORIGIN_X, $urandom);
            write_reg(mep_pkg::CSR_ORIGIN_Y, $urandom);
            write_reg(mep_pkg::CSR_STEP_X, $urandom);
            write_reg(mep_pkg::CSR_STEP_Y, $urandom);
            write_reg(mep_pkg::CSR_MAX_ITER, {16'($urandom), 16'($urandom_range(1, 1024))});
            col_span = 4095;
            row_span = 4095;
         end
         default: begin
            // 64 x 48 grid over the whole set
            write_reg(mep_pkg::CSR_ORIGIN_X, 32'hD800_0000);
            write_reg(mep_pkg::CSR_ORIGIN_Y, 32'h1800_0000);
            write_reg(mep_pkg::CSR_STEP_X, 32'h0100_0000);
            write_reg(mep_pkg::CSR_STEP_Y, 32'h0100_0000);
            if (view == VIEW_LOW_LIMIT) begin
               write_reg(mep_pkg::CSR_MAX_ITER, 32'($urandom_range(1, 4)));
            end else begin
               write_reg(mep_pkg::CSR_MAX_ITER, 32'($urandom_range(16, 256)));
            end
            col_span = 63;
            row_span = 47;
         end
      endcase
   endtask

   initial begin : stimulus
      int p;
      int i;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      apply_idling(IDLE_BOTH);

      // reset setting: every pixel sits at c = 0, inside after 1024 steps
      region_count++;
      queue_pixel(4095, 4095);
      queue_pixel(0, 0);
      settle();

      // zero limit; the upper data bits must be dropped
      write_reg(mep_pkg::CSR_MAX_ITER, 32'hFFFF_0000);
      queue_pixel(0, 0);
      queue_pixel(4095, 0);
      settle();

      write_reg(mep_pkg::CSR_MAX_ITER, 32'd1);
      queue_pixel(0, 0);
      settle();
      write_reg(mep_pkg::CSR_ORIGIN_X, 32'h3000_0000);
      queue_pixel(0, 0);
      settle();

      // saturated corners, step bit 31 set in the write data
      write_reg(mep_pkg::CSR_ORIGIN_X, 32'h7FFF_FFFF);
      write_reg(mep_pkg::CSR_STEP_X, 32'hFFFF_FFFF);
      write_reg(mep_pkg::CSR_ORIGIN_Y, 32'h8000_0000);
      write_reg(mep_pkg::CSR_STEP_Y, 32'hFFFF_FFFF);
      write_reg(mep_pkg::CSR_MAX_ITER, 32'd10);
      queue_pixel(4095, 4095);
      queue_pixel(4095, 0);
      queue_pixel(0, 4095);
      queue_pixel(1, 1);
      settle();

      // slow escapes just right of the cusp; unmapped writes must change nothing
      region_count++;
      write_reg(mep_pkg::CSR_ORIGIN_X, 32'h0400_0400);
      write_reg(mep_pkg::CSR_ORIGIN_Y, 32'h0000_0000);
      write_reg(mep_pkg::CSR_STEP_X, 32'h0000_1000);
      write_reg(mep_pkg::CSR_STEP_Y, 32'h0000_0000);
      write_reg(mep_pkg::CSR_MAX_ITER, 32'd2000);
      write_reg(CSR_UNUSED_LO, 32'h7000_0000);
      write_reg(CSR_UNUSED_MID, 32'h7000_0000);
      write_reg(CSR_UNUSED_HI, 32'h7FFF_FFFF);
      queue_pixel(0, 0);
      queue_pixel(1, 0);
      queue_pixel(3, 0);
      queue_pixel(7, 0);
      queue_pixel(20, 0);
      queue_pixel(60, 0);
      queue_pixel(255, 0);
      queue_pixel(0, 4095);
      settle();

      // full 16-bit limit
      region_count++;
      write_reg(mep_pkg::CSR_ORIGIN_X, 32'h0000_0000);
      write_reg(mep_pkg::CSR_STEP_X, 32'h0100_0000);
      write_reg(mep_pkg::CSR_MAX_ITER, 32'h0000_FFFF);
      queue_pixel(0, 0);
      queue_pixel(8, 0);
      queue_pixel(4095, 0);
      settle();

      for (p = 0; p < RANDOM_PHASES; p++) begin
         apply_idling(idle_mode_type'(p % 4));
         pick_region(phase_views[p]);
         // hold the receiver off while the sender keeps offering
         if (p == 0) begin
            long_hold_armed = 1'b1;
         end
         for (i = 0; i < ITEMS_PER_PHASE; i++) begin
            queue_pixel($urandom_range(col_span), $urandom_range(row_span));
         end
         settle();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("summary: %0d pixels sent, %0d checked over %0d regions and limits",
               pixels_sent, pixels_checked, region_count);
      $display("summary: %0d mismatches, %0d predictions left over",
               fault_count, owed_pixels.size());
      if (fault_count == 0 && owed_pixels.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/mep_pkg.sv
rtl/mandelbrot_escape_pixel_core.sv
bench/testbench.sv
